### design/assert_macros.svh
// assertion macros used by the queue core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define KWQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication that must hold from the cycle after the trigger
`define KWQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

### design/kwq_pkg.sv
// package with types and constants for the keyed waitlist queue
`default_nettype none

package kwq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ID_W  = 32;
    localparam int KEY_W = 31;
    localparam int POS_W = 5;
    localparam int ST_W  = 3;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_POP    = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

### design/kwq_if.sv
// request and response channel interfaces
`default_nettype none

interface kwq_req_if;
    import kwq_pkg::*;
    logic                   valid;
    logic                   ready;
    cmd_t                   command;
    logic signed [ID_W-1:0] attendee_id;

    modport source (output valid, output command, output attendee_id, input ready);
    modport sink   (input valid, input command, input attendee_id, output ready);
endinterface

interface kwq_rsp_if;
    import kwq_pkg::*;
    logic             valid;
    logic             ready;
    status_t          status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] queue_size;
    logic [KEY_W-1:0] head_id;

    modport source (output valid, output status, output position, output queue_size,
                    output head_id, input ready);
    modport sink   (input valid, input status, input position, input queue_size,
                    input head_id, output ready);
endinterface

`default_nettype wire

### design/kwq_cell.sv
// one queue cell: holds a key, compares it and shifts toward the head
`default_nettype none

module kwq_cell (
    input  wire logic                      clk,
    input  wire kwq_pkg::cell_ctl_t        ctl,
    input  wire logic [kwq_pkg::KEY_W-1:0] load_key,
    input  wire logic [kwq_pkg::KEY_W-1:0] next_key,
    input  wire logic [kwq_pkg::KEY_W-1:0] cmp_key,
    input  wire logic                      cmp_en,
    output logic      [kwq_pkg::KEY_W-1:0] key,
    output logic                           match
);
    import kwq_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.shift)
        begin
            key_next = next_key;
        end
        else if (ctl.load)
        begin
            key_next = load_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign match = cmp_en && (key_reg == cmp_key);

endmodule

`default_nettype wire

### design/keyed_waitlist_queue_core.sv
// top level of the keyed waitlist queue: cell row, control and result register
// Each accepted item is one command (append, delete by key, pop head, query position) and
// is finished in the cycle it is accepted: every occupied cell compares its stored key against
// the item's key in parallel, a priority pick over the match bits gives the position, and on a
// delete or pop the cells at and behind that position take their neighbor's key. The result
// appears in an output register the next cycle, so one item per cycle is accepted while the
// response side takes results; a stalled result holds the request side until it is taken.
`default_nettype none

`include "assert_macros.svh"

module keyed_waitlist_queue_core (
    input  wire logic clk,
    input  wire logic rst_n,
    kwq_req_if.sink   req,
    kwq_rsp_if.source rsp
);
    import kwq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [POS_W-1:0] size_reg;
    logic [KEY_W-1:0] head_reg;
    logic [KEY_W-1:0] head_next;

    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [DEPTH-1:0] match_vec;
    cell_ctl_t        cell_ctl [DEPTH];

    logic             accept;
    logic             key_ok;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             full;
    logic             app_ok;
    logic             drop;
    logic [IDX_W-1:0] drop_idx;

    assign accept    = req.valid && req.ready;
    assign req.ready = !out_valid_reg || rsp.ready;
    assign key_ok    = (req.attendee_id != '0) && !req.attendee_id[ID_W-1];
    assign key       = req.attendee_id[KEY_W-1:0];
    assign full      = (count_reg == CNT_W'(DEPTH));

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0] nb_key;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nb_key = cell_key[gi];
            end
            else
            begin : g_mid
                assign nb_key = cell_key[gi + 1];
            end

            always_comb
            begin
                cell_ctl[gi].load  = accept && app_ok && (CNT_W'(gi) == count_reg);
                cell_ctl[gi].shift = accept && drop && (IDX_W'(gi) >= drop_idx);
            end

            kwq_cell u_cell (
                .clk      (clk),
                .ctl      (cell_ctl[gi]),
                .load_key (key),
                .next_key (nb_key),
                .cmp_key  (key),
                .cmp_en   (key_ok && (CNT_W'(gi) < count_reg)),
                .key      (cell_key[gi]),
                .match    (match_vec[gi])
            );
        end
    endgenerate

    // first matching cell
    always_comb
    begin
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit = |match_vec;

    always_comb
    begin
        status_next   = ST_OK;
        position_next = '0;
        app_ok        = 1'b0;
        drop          = 1'b0;
        drop_idx      = '0;
        count_next    = count_reg;
        case (req.command)
            CMD_APPEND:
            begin
                if (hit)
                begin
                    status_next   = ST_DUP;
                    position_next = POS_W'({1'b0, hit_idx} + 1'b1);
                end
                else if (!key_ok)
                begin
                    status_next = ST_INVALID;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    app_ok        = 1'b1;
                    count_next    = count_reg + 1'b1;
                    position_next = POS_W'(count_next);
                end
            end
            CMD_DELETE:
            begin
                if (hit)
                begin
                    drop       = 1'b1;
                    drop_idx   = hit_idx;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    drop       = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_QUERY:
            begin
                if (hit)
                begin
                    position_next = POS_W'({1'b0, hit_idx} + 1'b1);
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // head after the command
    always_comb
    begin
        if (count_next == '0)
        begin
            head_next = '0;
        end
        else if (app_ok && (count_reg == '0))
        begin
            head_next = key;
        end
        else if (drop && (drop_idx == '0))
        begin
            head_next = cell_key[1];
        end
        else
        begin
            head_next = cell_key[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            size_reg     <= POS_W'(count_next);
            head_reg     <= head_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.position   = position_reg;
    assign rsp.queue_size = size_reg;
    assign rsp.head_id    = head_reg;

    `KWQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "count above depth")
    `KWQ_ASSERT(a_unique_match, $onehot0(match_vec), "key matched in more than one cell")
    `KWQ_ASSERT_NEXT(a_append_grows, accept && app_ok,
        count_reg == CNT_W'($past(count_reg) + 1'b1), "append did not grow the queue")
    `KWQ_ASSERT_NEXT(a_result_follows, accept, rsp.valid, "accepted item gave no result")

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the keyed waitlist queue core
`default_nettype none

module tb_top;
    import kwq_pkg::*;

    localparam int RUN_LIMIT   = 200000;
    localparam int RANDOM_CMDS = 600;
    localparam int KEY_POOL_SZ = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] queue_size;
        logic [KEY_W-1:0] head_id;
    } queue_result_t;

    typedef struct {
        cmd_t                   command;
        logic signed [ID_W-1:0] attendee_id;
        bit                     drain_first;
    } queue_cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kwq_req_if req_ch ();
    kwq_rsp_if rsp_ch ();

    keyed_waitlist_queue_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [KEY_W-1:0]       waitlist_model[$];
    queue_result_t          expected_results[$];
    queue_cmd_t             pending_commands[$];
    queue_cmd_t             staged_cmd;
    logic signed [ID_W-1:0] key_pool[KEY_POOL_SZ];
    queue_result_t          seen_result;
    int                     status_counts[6];
    int                     cycle_count;
    int                     error_count;
    int                     commands_sent;
    int                     results_checked;
    int                     peak_size;
    int                     burst_left;
    int                     gap_left;
    int                     stall_left;
    bit                     sink_ready;

    // predicted result of one command, updates the model waitlist
    function automatic queue_result_t predict_command(cmd_t cmd, logic signed [ID_W-1:0] id);
        queue_result_t    res;
        logic             key_ok;
        logic [KEY_W-1:0] key;
        int               idx;
        key_ok = (id > 0);
        key    = id[KEY_W-1:0];
        idx    = -1;
        if (key_ok)
        begin
            for (int i = 0; i < waitlist_model.size() && idx < 0; i++)
            begin
                if (waitlist_model[i] == key)
                    idx = i;
            end
        end
        res.status   = ST_OK;
        res.position = '0;
        case (cmd)
            CMD_APPEND:
            begin
                if (idx >= 0)
                begin
                    res.status   = ST_DUP;
                    res.position = POS_W'(idx + 1);
                end
                else if (!key_ok)
                    res.status = ST_INVALID;
                else if (waitlist_model.size() >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    waitlist_model.push_back(key);
                    res.position = POS_W'(waitlist_model.size());
                end
            end
            CMD_DELETE:
            begin
                if (idx >= 0)
                    waitlist_model.delete(idx);
                else
                    res.status = ST_NOTFOUND;
            end
            CMD_POP:
            begin
                if (waitlist_model.size() == 0)
                    res.status = ST_EMPTY;
                else
                    void'(waitlist_model.pop_front());
            end
            default:
            begin
                if (idx >= 0)
                    res.position = POS_W'(idx + 1);
                else
                    res.status = ST_NOTFOUND;
            end
        endcase
        res.queue_size = POS_W'(waitlist_model.size());
        res.head_id    = (waitlist_model.size() > 0) ? waitlist_model[0] : '0;
        return res;
    endfunction

    task automatic add_command(cmd_t cmd, logic signed [ID_W-1:0] id, bit drain);
        queue_cmd_t c;
        c.command     = cmd;
        c.attendee_id = id;
        c.drain_first = drain;
        pending_commands.push_back(c);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // stimulus list
    initial
    begin
        logic signed [ID_W-1:0] id;
        int                     append_pct;
        int                     pick;
        cmd_t                   cmd;
        add_command(CMD_POP,    32'sd0, 1'b0);
        add_command(CMD_QUERY,  32'sd5, 1'b0);
        add_command(CMD_DELETE, 32'sd5, 1'b0);
        add_command(CMD_APPEND, 32'sd0, 1'b0);
        add_command(CMD_APPEND, -32'sd1, 1'b0);
        add_command(CMD_APPEND, 32'h8000_0000, 1'b0);
        add_command(CMD_APPEND, 32'h7FFF_FFFF, 1'b0);
        add_command(CMD_APPEND, 32'sd1, 1'b0);
        add_command(CMD_APPEND, 32'h7FFF_FFFF, 1'b0);
        add_command(CMD_QUERY,  32'sd1, 1'b0);
        add_command(CMD_QUERY,  -32'sd7, 1'b0);
        add_command(CMD_DELETE, 32'sd0, 1'b0);
        for (int k = 2; k < 16; k++)
            add_command(CMD_APPEND, 32'(k * 1000), 1'b0);
        add_command(CMD_APPEND, 32'sd77, 1'b0);
        add_command(CMD_DELETE, 32'sd5000, 1'b0);
        add_command(CMD_POP,    32'sd0, 1'b0);

        for (int k = 0; k < KEY_POOL_SZ; k++)
        begin
            if (k < 14)
                key_pool[k] = 32'(k + 1);
            else
            begin
                key_pool[k]     = $urandom;
                key_pool[k][31] = 1'b0;
                if (key_pool[k] == 0)
                    key_pool[k] = 32'sd1;
            end
        end

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            append_pct = ((n / 60) % 2 == 0) ? 65 : 20;
            if ($urandom_range(0, 99) < append_pct)
                cmd = CMD_APPEND;
            else
                cmd = cmd_t'($urandom_range(1, 3));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                id = $urandom;
            else if (pick < 11)
            begin
                case ($urandom_range(0, 2))
                    0:       id = 32'sd0;
                    1:       id = -32'sd1;
                    default: id = 32'h8000_0000;
                endcase
            end
            else
                id = key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
            add_command(cmd, id, (n % 150) == 0);
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.command     <= CMD_APPEND;
            req_ch.attendee_id <= '0;
            burst_left         = $urandom_range(1, 16);
            gap_left           = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(predict_command(req_ch.command, req_ch.attendee_id));
                commands_sent++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_commands.size() == 0 ||
                         (pending_commands[0].drain_first &&
                          (expected_results.size() > 0 || req_ch.valid)))
                    req_ch.valid <= 1'b0;
                else
                begin
                    staged_cmd = pending_commands.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.command     <= staged_cmd.command;
                    req_ch.attendee_id <= staged_cmd.attendee_id;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // response monitor and sink stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_result.status     = rsp_ch.status;
                seen_result.position   = rsp_ch.position;
                seen_result.queue_size = rsp_ch.queue_size;
                seen_result.head_id    = rsp_ch.head_id;
                results_checked++;
                if (seen_result.status <= ST_FULL)
                    status_counts[seen_result.status]++;
                if (int'(seen_result.queue_size) > peak_size)
                    peak_size = int'(seen_result.queue_size);
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result status=%0d pos=%0d size=%0d head=%0d",
                                 seen_result.status, seen_result.position,
                                 seen_result.queue_size, seen_result.head_id);
                end
                else if (seen_result !== expected_results[0])
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"ERROR: result %0d exp status=%s pos=%0d size=%0d head=%0d,",
                                  " got status=%0d pos=%0d size=%0d head=%0d"},
                                 results_checked, expected_results[0].status.name(),
                                 expected_results[0].position, expected_results[0].queue_size,
                                 expected_results[0].head_id, seen_result.status,
                                 seen_result.position, seen_result.queue_size,
                                 seen_result.head_id);
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            case ((cycle_count >> 8) % 4)
                0: sink_ready = 1'b1;
                1: sink_ready = ($urandom_range(0, 9) < 7);
                2: sink_ready = cycle_count[0];
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        sink_ready = 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(4, 16);
                        sink_ready = 1'b0;
                    end
                    else
                        sink_ready = 1'b1;
                end
            endcase
            rsp_ch.ready <= sink_ready;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // end of run
    initial
    begin
        @(posedge rst_n);
        while (pending_commands.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            error_count += expected_results.size();
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        $display("Ran %0d commands, checked %0d results, peak occupancy %0d of %0d",
                 commands_sent, results_checked, peak_size, DEPTH);
        $display("Status mix ok=%0d dup=%0d invalid=%0d notfound=%0d empty=%0d full=%0d",
                 status_counts[0], status_counts[1], status_counts[2],
                 status_counts[3], status_counts[4], status_counts[5]);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/kwq_pkg.sv
design/kwq_if.sv
design/kwq_cell.sv
design/keyed_waitlist_queue_core.sv
tb/tb_top.sv
